// ===== hdl/assert_macros.svh =====
// Assertion macros for the origin address selector RTL.
// Depends on nothing; included by oas_ctrl, which carries the assertions.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failure");

// Same, with a caller-supplied message string.
`define ASSERT_AT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_AT_MSG(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== hdl/oas_pkg.sv =====
// Shared types, constants and helpers of the origin address selector.
// No dependencies; used by oas_ctrl, oas_dp and origin_address_selector_core.
package oas_pkg;

    localparam int TBL_DEPTH = 16;                 // own address and rule table depth
    localparam int IDX_W     = $clog2(TBL_DEPTH);  // table index width
    localparam int CNT_W     = IDX_W + 1;          // counts 0..TBL_DEPTH
    localparam int PART_W    = 16;

    localparam logic [CNT_W-1:0]  TBL_MAX       = CNT_W'(TBL_DEPTH);
    localparam logic [PART_W-1:0] WILDCARD_PART = 16'hFF9D;  // -99 as a word
    localparam logic [PART_W-1:0] UNSET_PART    = 16'hFFA8;  // -88 as a word

    typedef enum logic [1:0] {
        FUNC_WR_OWN  = 2'd0,
        FUNC_WR_RULE = 2'd1,
        FUNC_RESOLVE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    // Register indexes of the configuration port
    typedef enum logic {
        REG_OWN_COUNT  = 1'b0,
        REG_RULE_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_HOME,
        RES_PICK,
        RES_FIRST
    } t_res_op;

    typedef struct packed {
        logic [PART_W-1:0] zone;
        logic [PART_W-1:0] net;
        logic [PART_W-1:0] node;
        logic [PART_W-1:0] point;
    } t_addr;

    typedef struct packed {
        t_addr            mask;
        logic [IDX_W-1:0] tgt;
    } t_rule;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             wr_own;
        logic             wr_rule;
        logic [IDX_W-1:0] own_raddr;
        logic [IDX_W-1:0] rule_raddr;
        logic             zone_eval;
        logic             net_eval;
        t_res_op          res_op;
        logic             emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             orig_unset;
        logic             rule_hit;
        logic [IDX_W-1:0] rule_tgt;
        logic             net_home_hit;
        logic             hit_any;
        logic             hit_multi;
        logic             final_home;
        logic             out_free;
    } t_sts;

    function automatic logic part_hits(logic [PART_W-1:0] dst, logic [PART_W-1:0] mask);
        part_hits = (mask == WILDCARD_PART) || (dst == mask);
    endfunction

    function automatic logic mask_hits(t_addr dst, t_addr mask);
        mask_hits = part_hits(dst.zone, mask.zone) && part_hits(dst.net, mask.net) &&
                    part_hits(dst.node, mask.node) && part_hits(dst.point, mask.point);
    endfunction

endpackage

// ===== hdl/oas_ctrl.sv =====
// Sequencer of the origin address selector: accepts transactions and walks
// the rule table and the own address table through the datapath.
// Depends on oas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module oas_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_func,
    input  logic [oas_pkg::CNT_W-1:0]  i_own_cnt,
    input  logic [oas_pkg::CNT_W-1:0]  i_rule_cnt,
    input  oas_pkg::t_sts              i_sts,
    output oas_pkg::t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RULE,
        S_PICK,
        S_ZONE,
        S_NET,
        S_EMIT
    } t_state;

    t_state                     r_state, n_state;
    logic [oas_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                       r_pend, n_pend;
    logic [oas_pkg::CNT_W-1:0]  n_rules, n_own, n_scan;
    logic                       in_acc, issue, scan_done;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign n_rules = (i_rule_cnt > oas_pkg::TBL_MAX) ? oas_pkg::TBL_MAX : i_rule_cnt;
    assign n_own   = (i_own_cnt  > oas_pkg::TBL_MAX) ? oas_pkg::TBL_MAX : i_own_cnt;
    assign n_scan  = (r_state == S_RULE) ? n_rules : n_own;

    assign issue     = (r_idx < n_scan);
    assign scan_done = !r_pend && !issue;

    always_comb begin
        o_cmd            = '0;
        o_cmd.res_op     = oas_pkg::RES_HOLD;
        o_cmd.own_raddr  = r_idx[oas_pkg::IDX_W-1:0];
        o_cmd.rule_raddr = r_idx[oas_pkg::IDX_W-1:0];
        n_state          = r_state;
        n_idx            = issue ? r_idx + 1'b1 : r_idx;
        n_pend           = issue;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (oas_pkg::t_func'(i_func))
                        oas_pkg::FUNC_WR_OWN:  o_cmd.wr_own  = 1'b1;
                        oas_pkg::FUNC_WR_RULE: o_cmd.wr_rule = 1'b1;
                        oas_pkg::FUNC_RESOLVE: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_CHECK;
                        end
                        default: ;  // unused selector: drop
                    endcase
                end
            end
            S_CHECK: begin
                n_state = i_sts.orig_unset ? S_RULE : S_EMIT;
            end
            S_RULE: begin
                if (r_pend && i_sts.rule_hit) begin
                    o_cmd.own_raddr = i_sts.rule_tgt;
                    n_state         = S_PICK;
                end else if (scan_done) begin
                    if (n_own <= oas_pkg::CNT_W'(1)) begin
                        o_cmd.res_op = oas_pkg::RES_HOME;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_ZONE;
                    end
                end
            end
            S_PICK: begin
                o_cmd.res_op = oas_pkg::RES_PICK;
                n_state      = S_EMIT;
            end
            S_ZONE: begin
                o_cmd.zone_eval = r_pend;
                if (scan_done) begin
                    if (!i_sts.hit_any) begin
                        o_cmd.res_op = oas_pkg::RES_HOME;
                        n_state      = S_EMIT;
                    end else if (i_sts.hit_multi) begin
                        n_state = S_NET;
                    end else begin
                        o_cmd.res_op = i_sts.final_home ? oas_pkg::RES_HOME
                                                        : oas_pkg::RES_FIRST;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_NET: begin
                o_cmd.net_eval = r_pend;
                if (r_pend && i_sts.net_home_hit) begin
                    o_cmd.res_op = oas_pkg::RES_HOME;
                    n_state      = S_EMIT;
                end else if (scan_done) begin
                    o_cmd.res_op = i_sts.final_home ? oas_pkg::RES_HOME
                                                    : oas_pkg::RES_FIRST;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // every scan starts from entry zero with nothing in flight
        if (n_state != r_state) begin
            n_idx  = '0;
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    `ASSERT_AT_MSG(a_resolve_leaves_idle, i_clk, i_rst_n,
        (in_acc && (oas_pkg::t_func'(i_func) == oas_pkg::FUNC_RESOLVE)) |=> (r_state == S_CHECK),
        "resolve accepted but sequencer did not start")
    `ASSERT_AT(a_pend_after_issue, i_clk, i_rst_n, r_pend |-> (r_idx != '0))
    `ASSERT_AT(a_idx_in_table, i_clk, i_rst_n, r_idx <= oas_pkg::TBL_MAX)
    `ASSERT_AT_MSG(a_emit_into_free_slot, i_clk, i_rst_n, o_cmd.emit |-> i_sts.out_free,
        "result loaded over an untaken result")

endmodule

// ===== hdl/oas_dp.sv =====
// Datapath of the origin address selector: table memories, compare logic,
// scan flags, working result and output register. Depends on oas_pkg.
module oas_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oas_pkg::t_cmd               i_cmd,
    output oas_pkg::t_sts               o_sts,
    input  logic [oas_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [15:0]                 i_addr_zone,
    input  logic [15:0]                 i_addr_net,
    input  logic [15:0]                 i_addr_node,
    input  logic [15:0]                 i_addr_point,
    input  logic [oas_pkg::IDX_W-1:0]   i_rule_target,
    input  logic [15:0]                 i_orig_zone,
    input  logic [15:0]                 i_orig_net,
    input  logic [15:0]                 i_orig_node,
    input  logic [15:0]                 i_orig_point,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [15:0]                 o_out_zone,
    output logic [15:0]                 o_out_net,
    output logic [15:0]                 o_out_node,
    output logic [15:0]                 o_out_point,
    output logic                        o_changed
);

    oas_pkg::t_addr r_own_mem  [oas_pkg::TBL_DEPTH];
    oas_pkg::t_rule r_rule_mem [oas_pkg::TBL_DEPTH];

    oas_pkg::t_addr r_own_rd, r_home, r_dst, r_res, r_first, r_out;
    oas_pkg::t_rule r_rule_rd;
    logic           r_chg, r_out_chg, r_out_valid;
    logic           r_hit_any, r_hit_multi, r_cur_zone, r_zone_net;

    oas_pkg::t_addr in_addr, in_orig;
    logic           zone_eq, net_eq, home_eq;

    assign in_addr = '{zone: i_addr_zone, net: i_addr_net, node: i_addr_node,
                       point: i_addr_point};
    assign in_orig = '{zone: i_orig_zone, net: i_orig_net, node: i_orig_node,
                       point: i_orig_point};

    assign zone_eq = (r_own_rd.zone == r_dst.zone);
    assign net_eq  = (r_own_rd.net  == r_dst.net);
    assign home_eq = (r_own_rd == r_home);

    assign o_sts.orig_unset   = (r_res.zone == oas_pkg::UNSET_PART) &&
                                (r_res.net  == oas_pkg::UNSET_PART) &&
                                (r_res.node == oas_pkg::UNSET_PART) &&
                                (r_res.point == oas_pkg::UNSET_PART);
    assign o_sts.rule_hit     = oas_pkg::mask_hits(r_dst, r_rule_rd.mask);
    // a 4-bit target cannot exceed the last own entry, so no clamp is needed
    assign o_sts.rule_tgt     = r_rule_rd.tgt;
    assign o_sts.net_home_hit = zone_eq && net_eq && home_eq;
    assign o_sts.hit_any      = r_hit_any;
    assign o_sts.hit_multi    = r_hit_multi;
    assign o_sts.final_home   = (r_cur_zone && !r_zone_net) || (r_first == r_home);
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    // table memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_own) begin
            r_own_mem[i_entry_index] <= in_addr;
        end
        if (i_cmd.wr_rule) begin
            r_rule_mem[i_entry_index] <= '{mask: in_addr, tgt: i_rule_target};
        end
        r_own_rd  <= r_own_mem[i_cmd.own_raddr];
        r_rule_rd <= r_rule_mem[i_cmd.rule_raddr];
    end

    // shadow of own entry zero, compared against every scanned entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_own && (i_entry_index == '0)) begin
            r_home <= in_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dst <= in_addr;
            r_res <= in_orig;
            r_chg <= 1'b0;
        end else begin
            case (i_cmd.res_op)
                oas_pkg::RES_HOME: begin
                    r_res <= r_home;
                    r_chg <= 1'b0;
                end
                oas_pkg::RES_PICK: begin
                    r_res <= r_own_rd;
                    r_chg <= !home_eq;
                end
                oas_pkg::RES_FIRST: begin
                    r_res <= r_first;
                    r_chg <= 1'b1;
                end
                default: ;
            endcase
        end
        if (i_cmd.zone_eval && zone_eq && !r_hit_any) begin
            r_first <= r_own_rd;
        end else if (i_cmd.net_eval && zone_eq && net_eq && !r_zone_net) begin
            r_first <= r_own_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_hit_any   <= 1'b0;
            r_hit_multi <= 1'b0;
            r_cur_zone  <= 1'b0;
            r_zone_net  <= 1'b0;
        end else begin
            if (i_cmd.zone_eval && zone_eq) begin
                r_hit_any   <= 1'b1;
                r_hit_multi <= r_hit_any;
                if (home_eq) begin
                    r_cur_zone <= 1'b1;
                end
            end
            if (i_cmd.net_eval && zone_eq && net_eq) begin
                r_zone_net <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out     <= r_res;
            r_out_chg <= r_chg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_zone  = r_out.zone;
    assign o_out_net   = r_out.net;
    assign o_out_node  = r_out.node;
    assign o_out_point = r_out.point;
    assign o_changed   = r_out_chg;

endmodule

// ===== hdl/origin_address_selector_core.sv =====
// Top level of the origin address selector: configuration registers on an
// APB-style port, sequencer and datapath. Depends on oas_pkg, oas_ctrl, oas_dp.
//
// Use: every input transaction carries i_func. Func 0 writes own address
// entry i_entry_index, func 1 writes forced rule i_entry_index (mask plus
// i_rule_target), func 3 is dropped; none of these returns a result. Func 2
// resolves an origin and returns exactly one output transaction.
// A write does not stall the input; the block stalls its input only while a resolve is
// in progress. A resolve runs a check step, then for an unset origin a scan of the rule
// table and up to two scans over the own addresses (one entry per cycle through the
// registered read port of its table), then an emit step. A pass-through origin goes
// straight from the check to the emit. The next transaction is taken in the cycle after
// the emit. The result sits in an output register; while the receiver stalls it holds,
// and a following write is still taken. A new resolve waits at its last step until that
// register is free.
// Reset clears the sequencer and the output valid, and sets own_address_count
// to 1 and forced_rule_count to 0; the tables hold nothing until written.
// Write configuration only while the block is idle; a write takes effect at once.
module origin_address_selector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_entry_index,
    input  logic [15:0] i_addr_zone,
    input  logic [15:0] i_addr_net,
    input  logic [15:0] i_addr_node,
    input  logic [15:0] i_addr_point,
    input  logic [3:0]  i_rule_target,
    input  logic [15:0] i_orig_zone,
    input  logic [15:0] i_orig_net,
    input  logic [15:0] i_orig_node,
    input  logic [15:0] i_orig_point,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_zone,
    output logic [15:0] o_out_net,
    output logic [15:0] o_out_node,
    output logic [15:0] o_out_point,
    output logic        o_changed
);

    logic [oas_pkg::CNT_W-1:0] r_own_cnt;
    logic [oas_pkg::CNT_W-1:0] r_rule_cnt;
    logic                      cfg_wr;
    oas_pkg::t_reg_idx         cfg_idx;
    oas_pkg::t_cmd             cmd;
    oas_pkg::t_sts             sts;

    // byte lanes within a word are ignored; bit 2 picks the register
    assign cfg_idx = oas_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_cnt  <= oas_pkg::CNT_W'(1);
            r_rule_cnt <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                oas_pkg::REG_OWN_COUNT:  r_own_cnt  <= pwdata[oas_pkg::CNT_W-1:0];
                oas_pkg::REG_RULE_COUNT: r_rule_cnt <= pwdata[oas_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            oas_pkg::REG_OWN_COUNT:  prdata = 32'(r_own_cnt);
            oas_pkg::REG_RULE_COUNT: prdata = 32'(r_rule_cnt);
            default:                 prdata = '0;
        endcase
    end

    // sequencer: owns the handshake on the input side
    oas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_own_cnt  (r_own_cnt),
        .i_rule_cnt (r_rule_cnt),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: tables, compares and the output register
    oas_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_entry_index (i_entry_index),
        .i_addr_zone   (i_addr_zone),
        .i_addr_net    (i_addr_net),
        .i_addr_node   (i_addr_node),
        .i_addr_point  (i_addr_point),
        .i_rule_target (i_rule_target),
        .i_orig_zone   (i_orig_zone),
        .i_orig_net    (i_orig_net),
        .i_orig_node   (i_orig_node),
        .i_orig_point  (i_orig_point),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_zone    (o_out_zone),
        .o_out_net     (o_out_net),
        .o_out_node    (o_out_node),
        .o_out_point   (o_out_point),
        .o_changed     (o_changed)
    );

endmodule
